@@ hdl/cpp_pkg.sv @@
// Shared types and constants for the capnometer packet parser.
package cpp_pkg;

   localparam int FRAME_LEN    = 8;
   localparam int WINDOW_DEPTH = 10;
   localparam int WINDOW_DROP  = 4;
   localparam int NUM_OFFSETS  = WINDOW_DEPTH - FRAME_LEN + 1;
   localparam int IDX_W        = $clog2(FRAME_LEN + 1);
   localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
   localparam int OFF_W        = $clog2(NUM_OFFSETS + 1);
   localparam logic [7:0] END_TIDAL_CAP = 8'd150;

   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] EV_GOOD     = 2'd0;
   localparam logic [1:0] EV_REJECT   = 2'd1;
   localparam logic [1:0] EV_SYNC_TO  = 2'd2;
   localparam logic [1:0] EV_PACKET_TO = 2'd3;

   localparam logic [2:0] REG_HEADER = 3'd0;
   localparam logic [2:0] REG_RATE   = 3'd1;
   localparam logic [2:0] REG_WAVE   = 3'd2;
   localparam logic [2:0] REG_ETCO2  = 3'd3;
   localparam logic [2:0] REG_STREAK = 3'd4;
   localparam logic [2:0] REG_SYNCTO = 3'd5;
   localparam logic [2:0] REG_PKTTO  = 3'd6;

   typedef struct packed {
      logic [7:0]  header_value;
      logic [7:0]  rate_limit;
      logic [7:0]  wave_limit;
      logic [7:0]  end_tidal_limit;
      logic [7:0]  streak_threshold;
      logic [15:0] sync_timeout_ms;
      logic [15:0] packet_timeout_ms;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic frame_write;   // store rx byte at frame index, advance it
      logic frame_start;   // store header byte, index to one
      logic frame_clear;   // index to zero
      logic win_write;     // append byte to the window
      logic win_clear;
      logic win_drop;      // shift out the oldest bytes
      logic win_copy;      // copy window at scan offset into the frame
      logic scan_start;
      logic scan_next;
      logic check_frame;   // evaluate the frame into the check flag
      logic check_window;  // evaluate the window at the scan offset
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_last;    // next frame write completes the packet
      logic win_last;      // window is full after the next write
      logic scan_done;     // no offsets left
      logic header_hit;    // window byte at scan offset equals header
      logic check_ok;
      logic byte_is_header;
   } stat_type;

endpackage

@@ hdl/cpp_datapath.sv @@
// Frame buffer, search window and packet check for the capnometer parser.
module cpp_datapath (
   input  logic               clock,
   input  cpp_pkg::cfg_type   cfg,
   input  cpp_pkg::cmd_type   cmd,
   input  logic [7:0]         rx_byte,
   output cpp_pkg::stat_type  stat,
   output logic [7:0]         frame_out [cpp_pkg::FRAME_LEN],
   input  logic               reset
);
   logic [7:0] frame_ff [cpp_pkg::FRAME_LEN];
   logic [7:0] win_ff [cpp_pkg::WINDOW_DEPTH];
   logic [cpp_pkg::IDX_W-1:0]  idx_ff;
   logic [cpp_pkg::FILL_W-1:0] fill_ff;
   logic [cpp_pkg::OFF_W-1:0]  off_ff;
   logic ok_ff;
   logic [7:0] cand [cpp_pkg::FRAME_LEN];
   logic [7:0] check_src [cpp_pkg::FRAME_LEN];
   logic cand_ok, check_in;

   always_comb begin
      for (int i = 0; i < cpp_pkg::FRAME_LEN; i++) begin
         if (int'(off_ff) + i < cpp_pkg::WINDOW_DEPTH)
            cand[i] = win_ff[int'(off_ff) + i];
         else
            cand[i] = 8'd0;
      end
   end

   function automatic logic pkt_ok(input logic [7:0] p [cpp_pkg::FRAME_LEN],
                                   input cpp_pkg::cfg_type c);
      logic [7:0] sum;
      logic [7:0] rr, wv, et;
      sum = 8'd0;
      for (int i = 0; i < cpp_pkg::FRAME_LEN - 1; i++) sum = sum + p[i];
      rr = (2 < cpp_pkg::FRAME_LEN - 1) ? p[2] : 8'd0;
      wv = (4 < cpp_pkg::FRAME_LEN - 1) ? p[4] : 8'd0;
      et = (5 < cpp_pkg::FRAME_LEN - 1) ? p[5] : 8'd0;
      return (sum == p[cpp_pkg::FRAME_LEN-1]) && (p[0] == c.header_value) &&
             (rr <= c.rate_limit) && (wv <= c.wave_limit) &&
             (et <= c.end_tidal_limit) && (et <= cpp_pkg::END_TIDAL_CAP);
   endfunction

   always_comb begin
      for (int i = 0; i < cpp_pkg::FRAME_LEN; i++)
         check_src[i] = cmd.check_window ? cand[i] : frame_ff[i];
      check_in  = pkt_ok(check_src, cfg);
      cand_ok   = check_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.check_frame || cmd.check_window) ok_ff <= cand_ok;
      if (cmd.frame_start) frame_ff[0] <= rx_byte;
      if (cmd.frame_write) frame_ff[idx_ff[$clog2(cpp_pkg::FRAME_LEN)-1:0]] <= rx_byte;
      if (cmd.win_copy) frame_ff <= cand;
      if (cmd.win_write) win_ff[fill_ff[$clog2(cpp_pkg::WINDOW_DEPTH)-1:0]] <= rx_byte;
      if (cmd.win_drop)
         for (int i = 0; i < cpp_pkg::WINDOW_DEPTH - cpp_pkg::WINDOW_DROP; i++)
            win_ff[i] <= win_ff[i + cpp_pkg::WINDOW_DROP];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         fill_ff <= '0;
         off_ff <= '0;
      end else begin
         if (cmd.frame_start) idx_ff <= cpp_pkg::IDX_W'(1);
         else if (cmd.frame_clear) idx_ff <= '0;
         else if (cmd.frame_write) idx_ff <= idx_ff + 1'b1;
         if (cmd.win_clear) fill_ff <= '0;
         else if (cmd.win_write) fill_ff <= fill_ff + 1'b1;
         else if (cmd.win_drop) fill_ff <= fill_ff - cpp_pkg::FILL_W'(cpp_pkg::WINDOW_DROP);
         if (cmd.scan_start) off_ff <= '0;
         else if (cmd.scan_next) off_ff <= off_ff + 1'b1;
      end
   end

   assign stat.frame_last = (int'(idx_ff) == cpp_pkg::FRAME_LEN - 1);
   assign stat.win_last   = (int'(fill_ff) == cpp_pkg::WINDOW_DEPTH - 1);
   assign stat.scan_done  = (int'(off_ff) >= cpp_pkg::NUM_OFFSETS);
   assign stat.header_hit = (cand[0] == cfg.header_value);
   assign stat.check_ok   = ok_ff;
   assign stat.byte_is_header = (rx_byte == cfg.header_value);
   assign frame_out = frame_ff;
endmodule

@@ hdl/cpp_controller.sv @@
// Control state machine, counters and statistics for the capnometer parser.
module cpp_controller (
   input  logic              clock,
   input  logic              reset,
   input  cpp_pkg::cfg_type  cfg,
   input  logic              req_go,
   input  logic [1:0]        req_opcode,
   input  cpp_pkg::stat_type stat,
   output cpp_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              ev_valid,
   output logic [1:0]        ev_kind,
   output logic              ev_packet,
   output logic [15:0]       good_total,
   output logic [15:0]       error_total,
   input  logic              ev_taken
);
   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_VERDICT, S_SCAN, S_SCAN_CHK, S_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic        reading_ff, timer_on_ff, seen_good_ff;
   logic [7:0]  streak_ff;
   logic [15:0] elapsed_ff, since_ff, good_ff, bad_ff;
   logic [1:0]  kind_ff;
   logic        pkt_ff;
   logic        searching, is_byte, is_tick, is_clear, sync_due, pkt_due;
   logic [15:0] elapsed_inc, since_inc;

   assign searching   = streak_ff > cfg.streak_threshold;
   assign is_byte     = req_go && (req_opcode == cpp_pkg::OP_BYTE);
   assign is_tick     = req_go && (req_opcode == cpp_pkg::OP_TICK);
   assign is_clear    = req_go && (req_opcode == cpp_pkg::OP_CLEAR);
   assign since_inc   = (since_ff != 16'hFFFF) ? since_ff + 16'd1 : since_ff;
   assign elapsed_inc = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
   // The sync timeout wins when both timeouts fall on the same tick.
   assign sync_due    = timer_on_ff && (elapsed_inc > cfg.sync_timeout_ms);
   assign pkt_due     = !sync_due && reading_ff && seen_good_ff &&
                        (since_inc > cfg.packet_timeout_ms);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (is_byte) begin
               if (reading_ff) begin
                  cmd.frame_write = 1'b1;
                  if (stat.frame_last) state_in = S_CHECK;
               end else if (searching) begin
                  cmd.win_write = 1'b1;
                  if (stat.win_last) begin
                     cmd.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
               end else if (stat.byte_is_header) begin
                  cmd.frame_start = 1'b1;
                  cmd.win_clear = 1'b1;
               end
            end else if (is_tick) begin
               if (sync_due) begin
                  cmd.frame_clear = 1'b1;
                  cmd.win_clear = 1'b1;
                  state_in = S_EMIT;
               end else if (pkt_due) begin
                  cmd.frame_clear = 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         S_CHECK: begin
            cmd.check_frame = 1'b1;
            cmd.frame_clear = 1'b1;
            state_in = S_VERDICT;
         end
         S_VERDICT: state_in = S_EMIT;
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.win_drop = 1'b1;
               state_in = S_IDLE;
            end else if (stat.header_hit) begin
               cmd.check_window = 1'b1;
               state_in = S_SCAN_CHK;
            end else cmd.scan_next = 1'b1;
         end
         S_SCAN_CHK: begin
            if (stat.check_ok) begin
               cmd.win_copy = 1'b1;
               cmd.win_clear = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_EMIT: if (ev_taken) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         reading_ff <= 1'b0;
         timer_on_ff <= 1'b0;
         seen_good_ff <= 1'b0;
         streak_ff <= '0;
         elapsed_ff <= '0;
         since_ff <= '0;
         good_ff <= '0;
         bad_ff <= '0;
         kind_ff <= cpp_pkg::EV_GOOD;
         pkt_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               if (is_byte) begin
                  if (reading_ff && stat.frame_last) reading_ff <= 1'b0;
                  else if (!reading_ff && !searching && stat.byte_is_header)
                     reading_ff <= 1'b1;
               end else if (is_tick) begin
                  since_ff <= since_inc;
                  if (sync_due) begin
                     streak_ff <= '0;
                     timer_on_ff <= 1'b0;
                     elapsed_ff <= '0;
                     reading_ff <= 1'b0;
                     kind_ff <= cpp_pkg::EV_SYNC_TO;
                     pkt_ff <= 1'b0;
                  end else begin
                     if (timer_on_ff) elapsed_ff <= elapsed_inc;
                     else if (searching) begin
                        timer_on_ff <= 1'b1;
                        elapsed_ff <= '0;
                     end
                     if (pkt_due) begin
                        if (streak_ff != 8'hFF) streak_ff <= streak_ff + 8'd1;
                        if (bad_ff != 16'hFFFF) bad_ff <= bad_ff + 16'd1;
                        reading_ff <= 1'b0;
                        kind_ff <= cpp_pkg::EV_PACKET_TO;
                        pkt_ff <= 1'b0;
                     end
                  end
               end else if (is_clear) begin
                  good_ff <= '0;
                  bad_ff <= '0;
                  since_ff <= '0;
                  seen_good_ff <= 1'b0;
               end
            end
            S_VERDICT, S_SCAN_CHK: begin
               if (stat.check_ok) begin
                  pkt_ff <= 1'b1;
                  kind_ff <= cpp_pkg::EV_GOOD;
                  streak_ff <= '0;
                  timer_on_ff <= 1'b0;
                  elapsed_ff <= '0;
                  if (good_ff != 16'hFFFF) good_ff <= good_ff + 16'd1;
                  since_ff <= '0;
                  seen_good_ff <= 1'b1;
               end else if (state_ff == S_VERDICT) begin
                  pkt_ff <= 1'b1;
                  kind_ff <= cpp_pkg::EV_REJECT;
                  if (streak_ff != 8'hFF) streak_ff <= streak_ff + 8'd1;
                  if (bad_ff != 16'hFFFF) bad_ff <= bad_ff + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign ev_valid    = (state_ff == S_EMIT);
   assign ev_kind     = kind_ff;
   assign ev_packet   = pkt_ff;
   assign good_total  = good_ff;
   assign error_total = bad_ff;
endmodule

@@ hdl/capnometer_packet_parser.sv @@
// Top level of the capnometer packet parser.
//
//  channel | direction | handshake              | content
//  req     | in        | req_tvalid/req_tready  | tuser opcode, tdata rx_byte
//  rsp     | out       | rsp_tvalid/rsp_tready  | tuser event_kind, tdata packet fields
//  csr     | in        | csr_valid/csr_ready    | register index and data
//
// A byte or tick that raises no event and fills no window is taken in the idle state. The
// byte that completes a packet passes a check state and a verdict state before its result
// is offered; a timeout result is offered in the cycle after its tick. A full search
// window is scanned offset by offset: an offset without a header is stepped over in the
// scan state, a checked offset also visits the scan check state, and bytes are dropped
// when none passes. The block holds one item at a time and waits in the result state
// while rsp_tready is low. Reset is synchronous and skips the frame and window buffers.
module capnometer_packet_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // status_byte, resp_rate, inspired_co2, co2_wave,
                                    // end_tidal_co2, pump_running, leak_seen,
                                    // occlusion_seen, good_total, error_total, 5 zero bits
   output logic [1:0]  rsp_tuser,   // event_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   cpp_pkg::cfg_type  cfg_ff;
   cpp_pkg::cmd_type  cmd;
   cpp_pkg::stat_type stat;
   logic [7:0]  frame [cpp_pkg::FRAME_LEN];
   logic        busy, ev_valid, ev_packet;
   logic [1:0]  ev_kind;
   logic [15:0] good_total, error_total;
   logic [7:0]  st, f2, f3, f4, f5;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value      <= 8'd6;
         cfg_ff.rate_limit        <= 8'd60;
         cfg_ff.wave_limit        <= 8'd50;
         cfg_ff.end_tidal_limit   <= 8'd120;
         cfg_ff.streak_threshold  <= 8'd3;
         cfg_ff.sync_timeout_ms   <= 16'd5000;
         cfg_ff.packet_timeout_ms <= 16'd2000;
      end else if (csr_valid) begin
         unique case (csr_index)
            cpp_pkg::REG_HEADER: cfg_ff.header_value     <= csr_data[7:0];
            cpp_pkg::REG_RATE:   cfg_ff.rate_limit       <= csr_data[7:0];
            cpp_pkg::REG_WAVE:   cfg_ff.wave_limit       <= csr_data[7:0];
            cpp_pkg::REG_ETCO2:  cfg_ff.end_tidal_limit  <= csr_data[7:0];
            cpp_pkg::REG_STREAK: cfg_ff.streak_threshold <= csr_data[7:0];
            cpp_pkg::REG_SYNCTO: cfg_ff.sync_timeout_ms  <= csr_data;
            cpp_pkg::REG_PKTTO:  cfg_ff.packet_timeout_ms <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   assign req_tready = !busy;

   cpp_controller u_ctrl (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .req_go(req_tvalid && !busy),
      .req_opcode(req_tuser), .stat(stat), .cmd(cmd), .busy(busy),
      .ev_valid(ev_valid), .ev_kind(ev_kind), .ev_packet(ev_packet),
      .good_total(good_total), .error_total(error_total), .ev_taken(rsp_tready));

   cpp_datapath u_dp (
      .clock(clock), .cfg(cfg_ff), .cmd(cmd), .rx_byte(req_tdata), .stat(stat),
      .frame_out(frame), .reset(reset));

   // Bytes past the checksum position read as zero in short frames.
   assign st = (ev_packet && 1 < cpp_pkg::FRAME_LEN - 1) ? frame[1] : 8'd0;
   assign f2 = (ev_packet && 2 < cpp_pkg::FRAME_LEN - 1) ? frame[2] : 8'd0;
   assign f3 = (ev_packet && 3 < cpp_pkg::FRAME_LEN - 1) ? frame[3] : 8'd0;
   assign f4 = (ev_packet && 4 < cpp_pkg::FRAME_LEN - 1) ? frame[4] : 8'd0;
   assign f5 = (ev_packet && 5 < cpp_pkg::FRAME_LEN - 1) ? frame[5] : 8'd0;

   assign rsp_tvalid = ev_valid;
   assign rsp_tuser  = ev_kind;
   assign rsp_tdata  = {5'd0, error_total, good_total, st[2], st[1],
                        ev_packet & ~st[0], f5, f4, f3, f2, st};
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the capnometer packet parser, with directed tests and random traffic.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // Layout of rsp_tdata, with the status byte in the lowest bits.
   typedef struct packed {
      logic [4:0]  pad;
      logic [15:0] error_total;
      logic [15:0] good_total;
      logic        occlusion_seen;
      logic        leak_seen;
      logic        pump_running;
      logic [7:0]  end_tidal_co2;
      logic [7:0]  co2_wave;
      logic [7:0]  inspired_co2;
      logic [7:0]  resp_rate;
      logic [7:0]  status_byte;
   } event_fields_type;

   typedef struct {
      logic [1:0]       kind;
      event_fields_type fields;
   } parser_event_type;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;   // status_byte, resp_rate, inspired_co2, co2_wave, end_tidal_co2,
                             // pump_running, leak_seen, occlusion_seen, good_total,
                             // error_total, 5 zero bits
   logic [1:0]  rsp_tuser;   // event_kind
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   capnometer_packet_parser dut (.*);

   // Shadow copy of the configuration registers.
   logic [7:0]  hdr_byte, rate_max, wave_max, etco2_max, streak_max;
   logic [15:0] sync_to_ms, pkt_to_ms;

   // Shadow copy of the parser state.
   logic        in_packet;
   logic [7:0]  pkt_bytes [cpp_pkg::FRAME_LEN];
   int          pkt_index;
   int          err_streak;
   logic [7:0]  sync_win [cpp_pkg::WINDOW_DEPTH];
   int          win_fill;
   logic        timer_running;
   int          timer_ms;
   int          ms_since_good;
   logic        had_good;
   int          good_cnt, bad_cnt;

   parser_event_type expected_events[$];
   int               mismatch_count;
   int               cycle_count;
   int               events_seen [4];
   int               items_sent;
   int               burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the run may never take longer than a generous multiple of its worst case.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // The receiver steps through three stall modes in turn: always ready, random stalls, or
   // ready with a chance of one in four. Each accepted result is checked here.
   always @(posedge clock) begin
      parser_event_type want;
      event_fields_type got;
      int               mode;
      mode = (cycle_count / 64) % 3;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_events.size() == 0) begin
            report_mismatch("result item kind with nothing pending", rsp_tuser, -1);
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser <= 2'd3) events_seen[rsp_tuser]++;
            if (rsp_tuser !== want.kind)
               report_mismatch("event_kind", rsp_tuser, want.kind);
            if (got.status_byte !== want.fields.status_byte)
               report_mismatch("status_byte", got.status_byte, want.fields.status_byte);
            if (got.resp_rate !== want.fields.resp_rate)
               report_mismatch("resp_rate", got.resp_rate, want.fields.resp_rate);
            if (got.inspired_co2 !== want.fields.inspired_co2)
               report_mismatch("inspired_co2", got.inspired_co2, want.fields.inspired_co2);
            if (got.co2_wave !== want.fields.co2_wave)
               report_mismatch("co2_wave", got.co2_wave, want.fields.co2_wave);
            if (got.end_tidal_co2 !== want.fields.end_tidal_co2)
               report_mismatch("end_tidal_co2", got.end_tidal_co2,
                               want.fields.end_tidal_co2);
            if (got.pump_running !== want.fields.pump_running)
               report_mismatch("pump_running", got.pump_running, want.fields.pump_running);
            if (got.leak_seen !== want.fields.leak_seen)
               report_mismatch("leak_seen", got.leak_seen, want.fields.leak_seen);
            if (got.occlusion_seen !== want.fields.occlusion_seen)
               report_mismatch("occlusion_seen", got.occlusion_seen,
                               want.fields.occlusion_seen);
            if (got.good_total !== want.fields.good_total)
               report_mismatch("good_total", got.good_total, want.fields.good_total);
            if (got.error_total !== want.fields.error_total)
               report_mismatch("error_total", got.error_total, want.fields.error_total);
            if (got.pad !== 5'd0)
               report_mismatch("tdata padding", got.pad, 0);
         end
      end
      case (mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 1) == 1);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // A frame passes when checksum, header and all limits hold.
   function automatic bit frame_passes(input logic [7:0] p [cpp_pkg::FRAME_LEN]);
      logic [7:0] sum;
      sum = 8'd0;
      for (int i = 0; i < cpp_pkg::FRAME_LEN - 1; i++) sum += p[i];
      if (sum != p[cpp_pkg::FRAME_LEN-1]) return 1'b0;
      if (p[0] != hdr_byte) return 1'b0;
      if (p[2] > rate_max) return 1'b0;
      if (p[4] > wave_max) return 1'b0;
      if (p[5] > etco2_max) return 1'b0;
      if (p[5] > cpp_pkg::END_TIDAL_CAP) return 1'b0;
      return 1'b1;
   endfunction

   function automatic parser_event_type make_event(input logic [1:0] kind,
                                                   input bit with_pkt);
      parser_event_type ev;
      logic [7:0]       st;
      st = with_pkt ? pkt_bytes[1] : 8'd0;
      ev.kind = kind;
      ev.fields = '0;
      ev.fields.status_byte    = st;
      ev.fields.resp_rate      = with_pkt ? pkt_bytes[2] : 8'd0;
      ev.fields.inspired_co2   = with_pkt ? pkt_bytes[3] : 8'd0;
      ev.fields.co2_wave       = with_pkt ? pkt_bytes[4] : 8'd0;
      ev.fields.end_tidal_co2  = with_pkt ? pkt_bytes[5] : 8'd0;
      ev.fields.pump_running   = with_pkt && !st[0];
      ev.fields.leak_seen      = st[1];
      ev.fields.occlusion_seen = st[2];
      ev.fields.good_total     = good_cnt[15:0];
      ev.fields.error_total    = bad_cnt[15:0];
      return ev;
   endfunction

   function automatic void count_good();
      err_streak = 0;
      timer_running = 1'b0;
      timer_ms = 0;
      if (good_cnt < 65535) good_cnt++;
      ms_since_good = 0;
      had_good = 1'b1;
   endfunction

   function automatic void count_bad();
      if (err_streak < 255) err_streak++;
      if (bad_cnt < 65535) bad_cnt++;
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      logic [7:0] cand [cpp_pkg::FRAME_LEN];
      if (in_packet) begin
         pkt_bytes[pkt_index] = b;
         pkt_index++;
         if (pkt_index < cpp_pkg::FRAME_LEN) return;
         in_packet = 1'b0;
         pkt_index = 0;
         if (frame_passes(pkt_bytes)) begin
            count_good();
            expected_events.push_back(make_event(cpp_pkg::EV_GOOD, 1'b1));
         end else begin
            count_bad();
            expected_events.push_back(make_event(cpp_pkg::EV_REJECT, 1'b1));
         end
         return;
      end
      if (err_streak > streak_max) begin
         // Sync search: fill the window, then try each offset that can hold a frame.
         sync_win[win_fill] = b;
         win_fill++;
         if (win_fill < cpp_pkg::WINDOW_DEPTH) return;
         for (int off = 0; off + cpp_pkg::FRAME_LEN <= cpp_pkg::WINDOW_DEPTH; off++) begin
            if (sync_win[off] != hdr_byte) continue;
            for (int i = 0; i < cpp_pkg::FRAME_LEN; i++) cand[i] = sync_win[off+i];
            if (frame_passes(cand)) begin
               pkt_bytes = cand;
               win_fill = 0;
               count_good();
               expected_events.push_back(make_event(cpp_pkg::EV_GOOD, 1'b1));
               return;
            end
         end
         for (int i = 0; i < cpp_pkg::WINDOW_DEPTH - cpp_pkg::WINDOW_DROP; i++)
            sync_win[i] = sync_win[i+cpp_pkg::WINDOW_DROP];
         win_fill -= cpp_pkg::WINDOW_DROP;
         return;
      end
      if (b == hdr_byte) begin
         win_fill = 0;
         pkt_bytes[0] = b;
         pkt_index = 1;
         in_packet = 1'b1;
      end
   endfunction

   function automatic void predict_tick();
      if (ms_since_good < 65535) ms_since_good++;
      if (timer_running) begin
         if (timer_ms < 65535) timer_ms++;
         if (timer_ms > sync_to_ms) begin
            // Sync timeout wins over a packet timeout due at the same tick.
            err_streak = 0;
            win_fill = 0;
            timer_running = 1'b0;
            timer_ms = 0;
            in_packet = 1'b0;
            pkt_index = 0;
            expected_events.push_back(make_event(cpp_pkg::EV_SYNC_TO, 1'b0));
            return;
         end
      end else if (err_streak > streak_max) begin
         timer_running = 1'b1;
         timer_ms = 0;
      end
      if (in_packet && had_good && ms_since_good > pkt_to_ms) begin
         count_bad();
         in_packet = 1'b0;
         pkt_index = 0;
         expected_events.push_back(make_event(cpp_pkg::EV_PACKET_TO, 1'b0));
      end
   endfunction

   function automatic void predict_item(input logic [1:0] op, input logic [7:0] b);
      case (op)
         cpp_pkg::OP_BYTE: predict_byte(b);
         cpp_pkg::OP_TICK: predict_tick();
         cpp_pkg::OP_CLEAR: begin
            good_cnt = 0;
            bad_cnt = 0;
            ms_since_good = 0;
            had_good = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Sends one item. Within a burst tvalid stays high into the next item; between
   // bursts it drops for a random gap.
   task automatic send_item(input logic [1:0] op, input logic [7:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_item(op, b);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drops tvalid and waits until every expected result has come, plus the
   // cycles the block may still spend scanning a window that reports nothing.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_events.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         cpp_pkg::REG_HEADER: hdr_byte   = value[7:0];
         cpp_pkg::REG_RATE:   rate_max   = value[7:0];
         cpp_pkg::REG_WAVE:   wave_max   = value[7:0];
         cpp_pkg::REG_ETCO2:  etco2_max  = value[7:0];
         cpp_pkg::REG_STREAK: streak_max = value[7:0];
         cpp_pkg::REG_SYNCTO: sync_to_ms = value;
         cpp_pkg::REG_PKTTO:  pkt_to_ms  = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [7:0] h, input logic [7:0] r, input logic [7:0] w,
                            input logic [7:0] e, input logic [7:0] s,
                            input logic [15:0] sto, input logic [15:0] pto);
      drain();
      write_reg(cpp_pkg::REG_HEADER, {8'd0, h});
      write_reg(cpp_pkg::REG_RATE, {8'd0, r});
      write_reg(cpp_pkg::REG_WAVE, {8'd0, w});
      write_reg(cpp_pkg::REG_ETCO2, {8'd0, e});
      write_reg(cpp_pkg::REG_STREAK, {8'd0, s});
      write_reg(cpp_pkg::REG_SYNCTO, sto);
      write_reg(cpp_pkg::REG_PKTTO, pto);
   endtask

   // Builds one frame with the current header and a checksum, optionally broken.
   function automatic void build_frame(output logic [7:0] f [cpp_pkg::FRAME_LEN],
                                       input logic [7:0] st, input logic [7:0] rate,
                                       input logic [7:0] insp, input logic [7:0] wave,
                                       input logic [7:0] et, input logic [6:0] extra,
                                       input bit bad_sum);
      logic [7:0] sum;
      f[0] = hdr_byte; f[1] = st; f[2] = rate; f[3] = insp; f[4] = wave; f[5] = et;
      f[6] = {1'b0, extra} ^ {extra[0], 7'd0};
      sum = 8'd0;
      for (int i = 0; i < cpp_pkg::FRAME_LEN - 1; i++) sum += f[i];
      f[7] = bad_sum ? sum + 8'd1 : sum;
   endfunction

   task automatic send_packet(input logic [7:0] st, input logic [7:0] rate,
                              input logic [7:0] insp, input logic [7:0] wave,
                              input logic [7:0] et, input bit bad_sum);
      logic [7:0] f [cpp_pkg::FRAME_LEN];
      build_frame(f, st, rate, insp, wave, et, 7'($urandom), bad_sum);
      for (int i = 0; i < cpp_pkg::FRAME_LEN; i++) send_item(cpp_pkg::OP_BYTE, f[i]);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(cpp_pkg::OP_TICK, 8'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Default limits: one good packet, then a bad checksum and a rate, wave and end-tidal
   // value over its limit, plus ignored noise and the unused opcode.
   task automatic test_packet_checks();
      send_item(cpp_pkg::OP_BYTE, 8'h00);
      send_item(cpp_pkg::OP_BYTE, 8'hFF);
      send_packet(8'h00, 8'd60, 8'd0, 8'd50, 8'd120, 1'b0);
      send_packet(8'h07, 8'd10, 8'd3, 8'd10, 8'd30, 1'b1);
      send_packet(8'h02, 8'd61, 8'd3, 8'd10, 8'd30, 1'b0);
      send_item(2'd3, 8'hAA);
      send_packet(8'h05, 8'd10, 8'd3, 8'd51, 8'd30, 1'b0);
      send_packet(8'hFF, 8'd10, 8'd3, 8'd10, 8'd121, 1'b0);
   endtask

   // With the end-tidal register at its maximum the fixed cap still rejects 151.
   task automatic test_end_tidal_cap();
      write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255, 16'd65535, 16'd65535);
      send_packet(8'h01, 8'hFF, 8'hFF, 8'hFF, 8'd150, 1'b0);
      send_packet(8'h01, 8'hFF, 8'hFF, 8'hFF, 8'd151, 1'b0);
   endtask

   // A zero threshold makes one reject start a sync search. A window holding a
   // frame at its last offset recovers; a window of noise drops four bytes.
   task automatic test_sync_search();
      logic [7:0] f [cpp_pkg::FRAME_LEN];
      write_all(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 16'd1);
      send_packet(8'h00, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
      for (int i = 0; i < 6; i++) send_item(cpp_pkg::OP_BYTE, 8'h11);
      build_frame(f, 8'h06, 8'd0, 8'd9, 8'd0, 8'd0, 7'd0, 1'b0);
      for (int i = 0; i < cpp_pkg::FRAME_LEN; i++) send_item(cpp_pkg::OP_BYTE, f[i]);
      // Back in sync: reject again, then let the search timer run out.
      send_packet(8'h00, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
      send_ticks(3);
   endtask

   // A partial packet is abandoned once the time since the last good packet
   // passes its limit; clearing the statistics disarms that.
   task automatic test_packet_timeout();
      write_all(8'h5A, 8'd200, 8'd200, 8'd200, 8'd10, 16'd100, 16'd1);
      send_packet(8'h00, 8'd5, 8'd5, 8'd5, 8'd5, 1'b0);
      send_item(cpp_pkg::OP_BYTE, 8'h5A);
      send_item(cpp_pkg::OP_BYTE, 8'h01);
      send_ticks(2);
      drain();
      send_item(cpp_pkg::OP_CLEAR, 8'h00);
      send_item(cpp_pkg::OP_BYTE, 8'h5A);
      send_ticks(3);
      send_item(cpp_pkg::OP_BYTE, 8'h00);
      send_packet(8'h04, 8'd1, 8'd1, 8'd1, 8'd1, 1'b0);
   endtask

   // Random phases: mostly well-formed packets with random content, with broken
   // ones, ticks, noise, clears and the unused opcode in between.
   task automatic test_random_traffic(input int n_items);
      int stop_at;
      int pick;
      logic [7:0] lim_r, lim_w, lim_e;
      lim_r = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(20, 255));
      lim_w = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(20, 255));
      lim_e = 8'($urandom_range(20, 255));
      write_all(8'($urandom), lim_r, lim_w, lim_e, 8'($urandom_range(0, 3)),
                16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)));
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_packet(8'($urandom), 8'($urandom_range(0, rate_max)), 8'($urandom),
                        8'($urandom_range(0, wave_max)),
                        8'($urandom_range(0, (etco2_max < 150) ? etco2_max : 150)),
                        $urandom_range(0, 4) == 0);
         end else if (pick < 62) begin
            send_packet(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 1'b0);
         end else if (pick < 80) begin
            send_ticks($urandom_range(1, 8));
         end else if (pick < 92) begin
            send_item(cpp_pkg::OP_BYTE, 8'($urandom));
         end else if (pick < 96) begin
            send_item(cpp_pkg::OP_CLEAR, 8'($urandom));
         end else begin
            send_item(2'd3, 8'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tuser = cpp_pkg::OP_BYTE;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = cpp_pkg::REG_HEADER;
      csr_data = 16'd0;
      mismatch_count = 0;
      cycle_count = 0;
      items_sent = 0;
      burst_left = 0;
      for (int k = 0; k < 4; k++) events_seen[k] = 0;
      hdr_byte = 8'd6; rate_max = 8'd60; wave_max = 8'd50; etco2_max = 8'd120;
      streak_max = 8'd3; sync_to_ms = 16'd5000; pkt_to_ms = 16'd2000;
      in_packet = 1'b0; pkt_index = 0; err_streak = 0; win_fill = 0;
      timer_running = 1'b0; timer_ms = 0; ms_since_good = 0; had_good = 1'b0;
      good_cnt = 0; bad_cnt = 0;
      for (int i = 0; i < cpp_pkg::FRAME_LEN; i++) pkt_bytes[i] = 8'd0;
      for (int i = 0; i < cpp_pkg::WINDOW_DEPTH; i++) sync_win[i] = 8'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_packet_checks();
      test_end_tidal_cap();
      test_sync_search();
      test_packet_timeout();
      for (int p = 0; p < 4; p++) test_random_traffic(75);

      drain();
      repeat (20) @(posedge clock);
      if (expected_events.size() != 0)
         report_mismatch("result items never arrived", expected_events.size(), 0);
      $display("Sent %0d items over %0d cycles with several limit and timeout settings.",
               items_sent, cycle_count);
      $display("Events checked: %0d good, %0d rejected, %0d sync timeout, %0d packet timeout.",
               events_seen[0], events_seen[1], events_seen[2], events_seen[3]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
